// ===== design/assert_macros.svh =====
// assertion macros used by the checker file tbar_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication into the next cycle, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/tbar_pkg.sv =====
// ----------------------------------------------------------------------------
// tbar_pkg
// shared constants and types of the tick bar aggregator
// ----------------------------------------------------------------------------
package tbar_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int TICKS_WIDTH = 16;
    localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 16'd100;

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [TICKS_WIDTH-1:0] ticks_t;

    typedef struct packed {
        logic advance;
        logic last;
    } step_ctrl_t;

endpackage

// ===== design/tick_bar_ohlcv_aggregator_unit.sv =====
// ----------------------------------------------------------------------------
// tick_bar_ohlcv_aggregator_unit
// Folds a stream of market records into OHLCV tick bars. A bar closes after
// ticks_per_bar records (zero counts as one) or on a record marked end of
// series, and is then offered with its first and last series index; volume
// saturates at its all-ones value. The unit takes one record per clock cycle
// with no gaps while the bar side keeps up: records land in an input register,
// max, min and saturating add logic folds each into the running bar, and a
// closed bar sits in the result register, so bar_valid rises once its last
// record has gone through the input register and the fold. While a bar waits
// in the result register under stall, the fold is frozen, so the input stalls
// as soon as a record sits in the input register behind it.
// ticks_per_bar may only be written while no record is in flight.
// ----------------------------------------------------------------------------
module tick_bar_ohlcv_aggregator_unit #(
    parameter int PRICE_WIDTH      = 32,
    parameter int VOLUME_SUM_WIDTH = 48,
    parameter int INDEX_WIDTH      = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  tbar_pkg::ticks_t            cfg_write_data,
    input  logic                        rec_valid,
    output logic                        rec_stall,
    input  tbar_pkg::field_t            open_price,
    input  tbar_pkg::field_t            high_price,
    input  tbar_pkg::field_t            low_price,
    input  tbar_pkg::field_t            close_price,
    input  tbar_pkg::field_t            trade_volume,
    input  logic                        end_of_series,
    output logic                        bar_valid,
    input  logic                        bar_stall,
    output logic [PRICE_WIDTH-1:0]      agg_open,
    output logic [PRICE_WIDTH-1:0]      agg_high,
    output logic [PRICE_WIDTH-1:0]      agg_low,
    output logic [PRICE_WIDTH-1:0]      agg_close,
    output logic [VOLUME_SUM_WIDTH-1:0] agg_volume,
    output logic [INDEX_WIDTH-1:0]      first_index,
    output logic [INDEX_WIDTH-1:0]      last_index
);
    import tbar_pkg::*;

    ticks_t                      ticks_per_bar_reg;

    logic                        in_vld_reg, in_vld_next;
    logic [PRICE_WIDTH-1:0]      in_open_reg, in_high_reg, in_low_reg, in_close_reg;
    field_t                      in_volume_reg;
    logic                        in_last_reg;

    logic                        out_vld_reg, out_vld_next;
    logic [PRICE_WIDTH-1:0]      out_open_reg, out_high_reg, out_low_reg, out_close_reg;
    logic [VOLUME_SUM_WIDTH-1:0] out_volume_reg;
    logic [INDEX_WIDTH-1:0]      out_first_reg, out_last_reg;

    logic                        blocked;
    logic                        rec_take;
    logic                        emit;
    step_ctrl_t                  ctrl;

    logic [PRICE_WIDTH-1:0]      f_open, f_high, f_low, f_close;
    logic [VOLUME_SUM_WIDTH-1:0] f_volume;
    logic [INDEX_WIDTH-1:0]      f_first, f_last;

    always_comb
    begin
        blocked      = out_vld_reg && bar_stall;
        ctrl.advance = in_vld_reg && !blocked;
        ctrl.last    = in_last_reg;
        rec_stall    = in_vld_reg && blocked;
        rec_take     = rec_valid && !rec_stall;
        in_vld_next  = rec_take || (in_vld_reg && blocked);
        out_vld_next = blocked || (ctrl.advance && emit);
    end

    tbar_accum #(
        .PRICE_WIDTH      (PRICE_WIDTH),
        .VOLUME_SUM_WIDTH (VOLUME_SUM_WIDTH),
        .INDEX_WIDTH      (INDEX_WIDTH)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .ticks_per_bar (ticks_per_bar_reg),
        .open_price    (in_open_reg),
        .high_price    (in_high_reg),
        .low_price     (in_low_reg),
        .close_price   (in_close_reg),
        .trade_volume  (in_volume_reg),
        .emit          (emit),
        .agg_open      (f_open),
        .agg_high      (f_high),
        .agg_low       (f_low),
        .agg_close     (f_close),
        .agg_volume    (f_volume),
        .first_index   (f_first),
        .last_index    (f_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_bar_reg <= TICKS_RESET;
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                ticks_per_bar_reg <= cfg_write_data;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            in_open_reg   <= PRICE_WIDTH'(open_price);
            in_high_reg   <= PRICE_WIDTH'(high_price);
            in_low_reg    <= PRICE_WIDTH'(low_price);
            in_close_reg  <= PRICE_WIDTH'(close_price);
            in_volume_reg <= trade_volume;
            in_last_reg   <= end_of_series;
        end
    end

    // bar payload
    always_ff @(posedge clk)
    begin
        if (ctrl.advance && emit)
        begin
            out_open_reg   <= f_open;
            out_high_reg   <= f_high;
            out_low_reg    <= f_low;
            out_close_reg  <= f_close;
            out_volume_reg <= f_volume;
            out_first_reg  <= f_first;
            out_last_reg   <= f_last;
        end
    end

    assign bar_valid   = out_vld_reg;
    assign agg_open    = out_open_reg;
    assign agg_high    = out_high_reg;
    assign agg_low     = out_low_reg;
    assign agg_close   = out_close_reg;
    assign agg_volume  = out_volume_reg;
    assign first_index = out_first_reg;
    assign last_index  = out_last_reg;

endmodule

// ===== design/tbar_accum.sv =====
// ----------------------------------------------------------------------------
// tbar_accum
// running bar state and the combinational fold of one record into it
// ----------------------------------------------------------------------------
module tbar_accum #(
    parameter int PRICE_WIDTH      = 32,
    parameter int VOLUME_SUM_WIDTH = 48,
    parameter int INDEX_WIDTH      = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbar_pkg::step_ctrl_t        ctrl,
    input  tbar_pkg::ticks_t            ticks_per_bar,
    input  logic [PRICE_WIDTH-1:0]      open_price,
    input  logic [PRICE_WIDTH-1:0]      high_price,
    input  logic [PRICE_WIDTH-1:0]      low_price,
    input  logic [PRICE_WIDTH-1:0]      close_price,
    input  tbar_pkg::field_t            trade_volume,
    output logic                        emit,
    output logic [PRICE_WIDTH-1:0]      agg_open,
    output logic [PRICE_WIDTH-1:0]      agg_high,
    output logic [PRICE_WIDTH-1:0]      agg_low,
    output logic [PRICE_WIDTH-1:0]      agg_close,
    output logic [VOLUME_SUM_WIDTH-1:0] agg_volume,
    output logic [INDEX_WIDTH-1:0]      first_index,
    output logic [INDEX_WIDTH-1:0]      last_index
);
    import tbar_pkg::*;

    localparam int VACC_WIDTH =
        ((VOLUME_SUM_WIDTH > FIELD_WIDTH) ? VOLUME_SUM_WIDTH : FIELD_WIDTH) + 1;

    ticks_t                        ticks_reg, ticks_next;
    logic [PRICE_WIDTH-1:0]        open_reg, open_next;
    logic [PRICE_WIDTH-1:0]        high_reg, high_next;
    logic [PRICE_WIDTH-1:0]        low_reg, low_next;
    logic [VOLUME_SUM_WIDTH-1:0]   volume_reg, volume_next;
    logic [INDEX_WIDTH-1:0]        start_reg, start_next;
    logic [INDEX_WIDTH-1:0]        index_reg, index_next;

    logic                          first;
    ticks_t                        threshold;
    ticks_t                        ticks_inc;
    logic [PRICE_WIDTH-1:0]        open_fold, high_fold, low_fold;
    logic [INDEX_WIDTH-1:0]        start_fold;
    logic [VOLUME_SUM_WIDTH-1:0]   volume_base, volume_sat;
    logic [VACC_WIDTH-1:0]         volume_sum;

    always_comb
    begin
        first       = (ticks_reg == '0);
        threshold   = (ticks_per_bar == '0) ? TICKS_WIDTH'(1) : ticks_per_bar;
        ticks_inc   = ticks_reg + TICKS_WIDTH'(1);
        open_fold   = first ? open_price : open_reg;
        high_fold   = (first || (high_price > high_reg)) ? high_price : high_reg;
        low_fold    = (first || (low_price < low_reg)) ? low_price : low_reg;
        start_fold  = first ? index_reg : start_reg;
        volume_base = first ? '0 : volume_reg;
        volume_sum  = VACC_WIDTH'(volume_base) + VACC_WIDTH'(trade_volume);
        // saturate at the all-ones sum
        if (volume_sum > VACC_WIDTH'({VOLUME_SUM_WIDTH{1'b1}}))
        begin
            volume_sat = '1;
        end
        else
        begin
            volume_sat = VOLUME_SUM_WIDTH'(volume_sum);
        end
        emit = (ticks_inc >= threshold) || ctrl.last;
    end

    always_comb
    begin
        ticks_next  = ticks_reg;
        open_next   = open_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        volume_next = volume_reg;
        start_next  = start_reg;
        index_next  = index_reg;
        if (ctrl.advance)
        begin
            ticks_next  = emit ? '0 : ticks_inc;
            open_next   = open_fold;
            high_next   = high_fold;
            low_next    = low_fold;
            volume_next = emit ? '0 : volume_sat;
            start_next  = start_fold;
            index_next  = (emit && ctrl.last) ? '0 : index_reg + INDEX_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= '0;
            open_reg   <= '0;
            high_reg   <= '0;
            low_reg    <= '1;
            volume_reg <= '0;
            start_reg  <= '0;
            index_reg  <= '0;
        end
        else
        begin
            ticks_reg  <= ticks_next;
            open_reg   <= open_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            volume_reg <= volume_next;
            start_reg  <= start_next;
            index_reg  <= index_next;
        end
    end

    assign agg_open    = open_fold;
    assign agg_high    = high_fold;
    assign agg_low     = low_fold;
    assign agg_close   = close_price;
    assign agg_volume  = volume_sat;
    assign first_index = start_fold;
    assign last_index  = index_reg;

endmodule

// ===== design/tbar_checker.sv =====
// ----------------------------------------------------------------------------
// tbar_checker
// port-level checks of the tick bar aggregator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbar_checker #(
    parameter int PRICE_WIDTH      = 32,
    parameter int VOLUME_SUM_WIDTH = 48,
    parameter int INDEX_WIDTH      = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rec_stall,
    input  logic                        bar_valid,
    input  logic                        bar_stall,
    input  logic [PRICE_WIDTH-1:0]      agg_open,
    input  logic [PRICE_WIDTH-1:0]      agg_high,
    input  logic [PRICE_WIDTH-1:0]      agg_low,
    input  logic [PRICE_WIDTH-1:0]      agg_close,
    input  logic [VOLUME_SUM_WIDTH-1:0] agg_volume,
    input  logic [INDEX_WIDTH-1:0]      first_index,
    input  logic [INDEX_WIDTH-1:0]      last_index
);

    // no bar is offered while in reset
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !bar_valid)

    // records only stall when a bar is waiting and held back
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, rec_stall, bar_valid && bar_stall)

    // a held bar stays offered
    `ASSERT_NEXT(a_bar_hold, clk, rst_n, bar_valid && bar_stall, bar_valid)

    // a held bar keeps its payload
    `ASSERT_NEXT(a_bar_stable, clk, rst_n, bar_valid && bar_stall,
        $stable(agg_open) && $stable(agg_high) && $stable(agg_low) &&
        $stable(agg_close) && $stable(agg_volume) && $stable(first_index) &&
        $stable(last_index))

endmodule

bind tick_bar_ohlcv_aggregator_unit tbar_checker #(
    .PRICE_WIDTH      (PRICE_WIDTH),
    .VOLUME_SUM_WIDTH (VOLUME_SUM_WIDTH),
    .INDEX_WIDTH      (INDEX_WIDTH)
) u_tbar_checker (.*);
